>>> sv/sync_length_checksum_frame_receiver_top_assert.svh
// Assertion macros used by the frame receiver core.
// Defining ASSERT_OFF compiles every check away.
`ifndef SYNC_LENGTH_CHECKSUM_FRAME_RECEIVER_TOP_ASSERT_SVH
`define SYNC_LENGTH_CHECKSUM_FRAME_RECEIVER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Check that is switched off while reset is held
`define SLCFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check that also runs during reset
`define SLCFR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SLCFR_ASSERT(lbl, prop, msg)
`define SLCFR_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> sv/slcfr_pkg.sv
package slcfr_pkg;

    // Input item modes
    localparam logic [1:0] MODE_ARM  = 2'd0;
    localparam logic [1:0] MODE_BYTE = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    // Result event codes
    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_GOOD    = 2'd1,
        EV_BAD     = 2'd2,
        EV_TIMEOUT = 2'd3
    } t_event;

    // Configuration register map (byte address bit 2 selects the register)
    localparam int unsigned CFG_ADDR_W  = 3;
    localparam logic        REG_SYNC    = 1'b0;
    localparam logic        REG_TIMEOUT = 1'b1;

    localparam logic [7:0]  SYNC_RESET    = 8'hAA;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  sync_value;
        logic [15:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] frame_type;
        logic [7:0] frame_length;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
    } t_result;

endpackage

>>> sv/slcfr_in_if.sv
// Input channel: one mode code and one received byte per transfer
interface slcfr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

>>> sv/slcfr_out_if.sv
// Result channel: one receiver event per transfer
interface slcfr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;

    modport source (output valid, output event_res, output frame_type, output frame_length,
                    output payload_byte, output byte_index, input ready);
    modport sink   (input valid, input event_res, input frame_type, input frame_length,
                    input payload_byte, input byte_index, output ready);
endinterface

>>> sv/sync_length_checksum_frame_receiver_top.sv
// Latency: a result is valid in the cycle after its input transfer.
// Throughput: one input transfer per cycle; the output register is refilled
// in the same cycle that its result is taken, so a stalled sink holds up input.
// Reset (i_rst_n, synchronous, active low): receiver idle and unarmed, no
// result pending, sync_value back to 0xAA and timeout_ticks back to 1000.
module sync_length_checksum_frame_receiver_top
    import slcfr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    slcfr_in_if.sink              i_item,
    slcfr_out_if.source           o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cfg w_cfg;

    // Configuration registers
    slcfr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Frame parser and result register
    slcfr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule

>>> sv/slcfr_cfg.sv
module slcfr_cfg
    import slcfr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [7:0]  r_sync_value;
    logic [15:0] r_timeout_ticks;
    logic        w_wr;

    // No wait states
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    // Register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value    <= SYNC_RESET;
            r_timeout_ticks <= TIMEOUT_RESET;
        end else if (w_wr) begin
            if (paddr[2] == REG_SYNC) begin
                r_sync_value <= pwdata[7:0];
            end else begin
                r_timeout_ticks <= pwdata[15:0];
            end
        end
    end

    // Read-back mux
    always_comb begin
        if (paddr[2] == REG_TIMEOUT) begin
            prdata = {16'd0, r_timeout_ticks};
        end else begin
            prdata = {24'd0, r_sync_value};
        end
    end

    assign o_cfg.sync_value    = r_sync_value;
    assign o_cfg.timeout_ticks = r_timeout_ticks;

endmodule

>>> sv/slcfr_core.sv
`include "sync_length_checksum_frame_receiver_top_assert.svh"

module slcfr_core
    import slcfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    slcfr_in_if.sink   i_item,
    slcfr_out_if.source o_result
);

    // Frame state
    logic        r_armed, n_armed;
    logic        r_in_frame, n_in_frame;
    logic [8:0]  r_byte_count, n_byte_count;
    logic [7:0]  r_held_type, n_held_type;
    logic [7:0]  r_held_length, n_held_length;
    logic [7:0]  r_running_sum, n_running_sum;
    logic [15:0] r_elapsed, n_elapsed;

    // Result register
    logic        r_out_valid;
    t_result     r_res, n_res;
    logic        n_has_res;

    logic        w_accept;
    logic [15:0] w_tick_next;
    logic [8:0]  w_pos;
    logic [8:0]  w_len9;

    // Output register frees up when empty or drained this cycle
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign w_accept     = i_item.valid && i_item.ready;

    assign w_tick_next = (r_elapsed != TICKS_MAX) ? (r_elapsed + 16'd1) : r_elapsed;
    assign w_pos       = r_byte_count - 9'd2;
    assign w_len9      = {1'b0, r_held_length};

    // Next state and result for the item on the input
    always_comb begin
        n_armed       = r_armed;
        n_in_frame    = r_in_frame;
        n_byte_count  = r_byte_count;
        n_held_type   = r_held_type;
        n_held_length = r_held_length;
        n_running_sum = r_running_sum;
        n_elapsed     = r_elapsed;
        n_has_res     = 1'b0;
        n_res.event_res    = EV_PAYLOAD;
        n_res.payload_byte = 8'd0;
        n_res.byte_index   = 8'd0;

        unique case (i_item.mode)
            MODE_ARM: begin
                n_armed       = 1'b1;
                n_in_frame    = 1'b0;
                n_byte_count  = 9'd0;
                n_held_type   = 8'd0;
                n_held_length = 8'd0;
                n_running_sum = 8'd0;
                n_elapsed     = 16'd0;
            end
            MODE_TICK: begin
                if (r_armed) begin
                    n_elapsed = w_tick_next;
                    if (w_tick_next >= i_cfg.timeout_ticks) begin
                        n_has_res       = 1'b1;
                        n_res.event_res = EV_TIMEOUT;
                        n_armed         = 1'b0;
                        n_in_frame      = 1'b0;
                    end
                end
            end
            MODE_BYTE: begin
                if (r_armed) begin
                    if (!r_in_frame) begin
                        // Hunting: only the sync byte matters
                        if (i_item.rx_byte == i_cfg.sync_value) begin
                            n_in_frame    = 1'b1;
                            n_byte_count  = 9'd0;
                            n_running_sum = 8'd0;
                        end
                    end else if (r_byte_count == 9'd0) begin
                        n_held_type   = i_item.rx_byte;
                        n_running_sum = i_item.rx_byte;
                        n_byte_count  = 9'd1;
                    end else if (r_byte_count == 9'd1) begin
                        n_held_length = i_item.rx_byte;
                        n_running_sum = r_running_sum + i_item.rx_byte;
                        n_byte_count  = 9'd2;
                    end else if (w_pos < w_len9) begin
                        // Payload byte goes straight out
                        n_running_sum      = r_running_sum + i_item.rx_byte;
                        n_byte_count       = r_byte_count + 9'd1;
                        n_has_res          = 1'b1;
                        n_res.event_res    = EV_PAYLOAD;
                        n_res.payload_byte = i_item.rx_byte;
                        n_res.byte_index   = w_pos[7:0];
                    end else begin
                        // Checksum byte gives the verdict
                        n_has_res       = 1'b1;
                        n_res.event_res = (r_running_sum == i_item.rx_byte) ? EV_GOOD : EV_BAD;
                        n_armed         = 1'b0;
                        n_in_frame      = 1'b0;
                    end
                end
            end
            default: begin
                // Unused mode: nothing happens
            end
        endcase

        n_res.frame_type   = n_held_type;
        n_res.frame_length = n_held_length;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_in_frame  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_armed     <= n_armed;
                r_in_frame  <= n_in_frame;
                r_out_valid <= n_has_res;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Counters and held frame fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= 9'd0;
            r_held_type   <= 8'd0;
            r_held_length <= 8'd0;
            r_running_sum <= 8'd0;
            r_elapsed     <= 16'd0;
        end else if (w_accept) begin
            r_byte_count  <= n_byte_count;
            r_held_type   <= n_held_type;
            r_held_length <= n_held_length;
            r_running_sum <= n_running_sum;
            r_elapsed     <= n_elapsed;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept && n_has_res) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.event_res    = r_res.event_res;
    assign o_result.frame_type   = r_res.frame_type;
    assign o_result.frame_length = r_res.frame_length;
    assign o_result.payload_byte = r_res.payload_byte;
    assign o_result.byte_index   = r_res.byte_index;

    // Checks
    `SLCFR_ASSERT(a_frame_needs_arm, r_in_frame |-> r_armed, "in frame while not armed")
    `SLCFR_ASSERT(a_count_in_range, (r_in_frame && (r_byte_count >= 9'd2)) |-> (w_pos <= w_len9), "payload count ran past declared length")
    `SLCFR_ASSERT(a_end_disarms, (w_accept && n_has_res && (n_res.event_res != EV_PAYLOAD)) |=> !r_armed, "verdict or timeout left the receiver armed")
    `SLCFR_ASSERT(a_payload_in_frame, (w_accept && n_has_res && (n_res.event_res == EV_PAYLOAD)) |=> r_in_frame, "payload byte issued outside a frame")
    `SLCFR_ASSERT_RST(a_reset_empty, !i_rst_n |=> !r_out_valid, "result pending after reset")

endmodule
